// File: src/lte_pkg.sv
// shared types and constants of the lsb text embedder
package lte_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned HLEN_W  = 16;
    localparam int unsigned STAGE_W = 3;
    localparam int unsigned BIT_W   = 3;
    localparam int unsigned CIDX_W  = 1;
    localparam int unsigned CDATA_W = 16;

    // reset values of the configuration registers
    localparam logic [HLEN_W-1:0] HLEN_RST   = 16'd54;
    localparam logic [BYTE_W-1:0] MARKER_RST = 8'd178;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_HEADER_LENGTH = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_MARKER_BYTE   = 1'b1;

    // stage codes reported with each result word
    localparam logic [STAGE_W-1:0] STAGE_HEADER = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_START  = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_TEXT   = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_END    = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_COPY   = 3'd4;

    // last bit position of an embedded byte
    localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

    // embedding phase, one-hot
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_START  = 5'b00010,
        PH_TEXT   = 5'b00100,
        PH_END    = 5'b01000,
        PH_COPY   = 5'b10000
    } phase_t;

    // result of one step
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               text_taken;
        logic [STAGE_W-1:0] stage;
    } step_res_t;

endpackage

// File: src/lte_core.sv
// embedding state machine and per-word bit substitution
module lte_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [lte_pkg::BYTE_W-1:0]  image_byte,
    input  logic [lte_pkg::BYTE_W-1:0]  text_byte,
    input  logic                        text_present,
    input  logic [lte_pkg::HLEN_W-1:0]  header_length,
    input  logic [lte_pkg::BYTE_W-1:0]  marker_byte,
    output lte_pkg::step_res_t          res
);
    import lte_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [HLEN_W-1:0]   header_count_reg, header_count_next;
    logic [BIT_W-1:0]    bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0]   bit_shifter_reg, bit_shifter_next;

    phase_t              eff_phase;
    logic [BIT_W-1:0]    eff_index;
    logic [BYTE_W-1:0]   src_byte;
    logic                in_header;

    // header check: once the count reaches the length the word starts the mark
    always_comb begin
        in_header = 1'b0;
        eff_phase = phase_reg;
        eff_index = bit_index_reg;
        if (phase_reg == PH_HEADER) begin
            if (header_count_reg < header_length) begin
                in_header = 1'b1;
            end else begin
                eff_phase = PH_START;
                eff_index = '0;
            end
        end
    end

    // pick the byte to embed, embed one bit, advance
    always_comb begin
        res.out_byte      = image_byte;
        res.text_taken    = 1'b0;
        res.stage         = STAGE_COPY;
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        bit_index_next    = bit_index_reg;
        bit_shifter_next  = bit_shifter_reg;
        src_byte          = bit_shifter_reg;

        if (in_header) begin
            res.stage         = STAGE_HEADER;
            header_count_next = header_count_reg + 1'b1;
        end else begin
            unique case (eff_phase)
                PH_START: begin
                    res.stage = STAGE_START;
                    if (eff_index == '0) begin
                        src_byte = marker_byte;
                    end
                    phase_next = (eff_index == BIT_LAST) ? PH_TEXT : PH_START;
                end
                PH_TEXT: begin
                    res.stage  = STAGE_TEXT;
                    phase_next = PH_TEXT;
                    if (eff_index == '0) begin
                        if (text_present) begin
                            src_byte       = text_byte;
                            res.text_taken = 1'b1;
                        end else begin
                            // text exhausted: this word opens the end mark
                            src_byte   = marker_byte;
                            res.stage  = STAGE_END;
                            phase_next = PH_END;
                        end
                    end
                end
                PH_END: begin
                    res.stage = STAGE_END;
                    if (eff_index == '0) begin
                        src_byte = marker_byte;
                    end
                    phase_next = (eff_index == BIT_LAST) ? PH_COPY : PH_END;
                end
                default: begin
                    res.stage  = STAGE_COPY;
                    phase_next = PH_COPY;
                end
            endcase

            // bit substitution for the embedding phases
            if (eff_phase == PH_START || eff_phase == PH_TEXT || eff_phase == PH_END) begin
                res.out_byte     = {image_byte[BYTE_W-1:1], src_byte[0]};
                bit_shifter_next = {1'b0, src_byte[BYTE_W-1:1]};
                bit_index_next   = (eff_index == BIT_LAST) ? '0 : eff_index + 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            bit_index_reg    <= '0;
            bit_shifter_reg  <= '0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            bit_index_reg    <= bit_index_next;
            bit_shifter_reg  <= bit_shifter_next;
        end
    end

endmodule

// File: src/lsb_text_embedder.sv
// lsb text embedder: one input word in, one result word out, state in lte_core
// the result of an accepted input word is registered in the output register
// throughput: 1 word per cycle while m_tready is high; the output register accepts while being drained
// reset: synchronous, active low; clears phase, counters, output valid and
// restores header_length to 54 and marker_byte to 178; no clearing pass
module lsb_text_embedder (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // image_byte[7:0], text_byte[15:8]
    input  logic                         s_tuser,   // text_present[0]
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // out_byte[7:0]
    output logic [3:0]                   m_tuser,   // text_taken[0], stage[3:1]
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lte_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [lte_pkg::CDATA_W-1:0]  cfg_data
);
    import lte_pkg::*;

    logic [HLEN_W-1:0]  header_length_reg;
    logic [BYTE_W-1:0]  marker_byte_reg;
    logic               m_tvalid_reg;
    step_res_t          res_reg;
    step_res_t          res;
    logic               accept;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_length_reg <= HLEN_RST;
            marker_byte_reg   <= MARKER_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_HEADER_LENGTH: header_length_reg <= cfg_data;
                CFG_MARKER_BYTE:   marker_byte_reg   <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // input handshake
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    lte_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (accept),
        .image_byte    (s_tdata[BYTE_W-1:0]),
        .text_byte     (s_tdata[2*BYTE_W-1:BYTE_W]),
        .text_present  (s_tuser),
        .header_length (header_length_reg),
        .marker_byte   (marker_byte_reg),
        .res           (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg.out_byte;
    assign m_tuser  = {res_reg.stage, res_reg.text_taken};

endmodule

// File: src/lte_checker.sv
// port-level checks for the lsb text embedder, bound to the top level
module lte_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [3:0]  m_tuser
);
    import lte_pkg::*;

    // a stalled result word holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // text is only consumed by a text-stage word
    a_taken_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[3:1] == STAGE_TEXT)
        else $error("text_taken outside the text stage");

    // stage code stays within the five phases
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[3:1] <= STAGE_COPY)
        else $error("stage code out of range");

    // an accepted word always yields a result word next cycle
    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind lsb_text_embedder lte_checker u_lte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
